// File: hw/rtl/lc3b_pkg.sv
// LC-3b executor package: opcodes, modes, state encoding and memory sizing.
// Used by lc3b_instruction_execute_unit; no dependencies.
package lc3b_pkg;

    localparam int MEM_WORDS = 32768;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int NUM_REGS  = 8;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_STEP  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        OP_BR   = 4'd0,
        OP_ADD  = 4'd1,
        OP_LDB  = 4'd2,
        OP_STB  = 4'd3,
        OP_JSR  = 4'd4,
        OP_AND  = 4'd5,
        OP_LDW  = 4'd6,
        OP_STW  = 4'd7,
        OP_RTI  = 4'd8,
        OP_XOR  = 4'd9,
        OP_RSV1 = 4'd10,
        OP_RSV2 = 4'd11,
        OP_JMP  = 4'd12,
        OP_SHF  = 4'd13,
        OP_LEA  = 4'd14,
        OP_TRAP = 4'd15
    } t_opcode;

    typedef enum logic [1:0] {
        MW_NONE = 2'd0,
        MW_BYTE = 2'd1,
        MW_WORD = 2'd2
    } t_mem_write;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_DATA,
        ST_RESULT
    } t_state;

    function automatic logic [MEM_AW-1:0] word_index(input logic [15:0] byte_addr);
        return byte_addr[MEM_AW:1];
    endfunction

endpackage

// File: hw/rtl/lc3b_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module lc3b_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: hw/rtl/lc3b_instruction_execute_unit.sv
// LC-3b executor: load, start, and single-step over one synchronous memory.
// Load/start/none/halt: IDLE, RESULT. ALU, branch, jump, LEA, STW also FETCH, DECODE.
// LDB, LDW, STB, TRAP add DATA (fetch read, then one data or vector access, one port).
// One request in flight; a new request is taken the cycle after the result is taken.
// Reset: registers clear, PC zero, Z set; memory contents undefined.
// Depends on lc3b_pkg and lc3b_ram.
module lc3b_instruction_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_address,
    input  logic [15:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pc,
    output logic        o_flag_n,
    output logic        o_flag_z,
    output logic        o_flag_p,
    output logic        o_halted,
    output logic        o_reg_written,
    output logic [2:0]  o_reg_index,
    output logic [15:0] o_reg_value,
    output logic [1:0]  o_mem_written,
    output logic [15:0] o_mem_address,
    output logic [15:0] o_mem_data
);
    localparam int AW = lc3b_pkg::MEM_AW;

    lc3b_pkg::t_state r_state, n_state;

    logic [15:0] r_regs [lc3b_pkg::NUM_REGS];
    logic [15:0] r_pc, r_ir, r_ea, r_rval, r_mdata;
    logic        r_n, r_z, r_p;
    logic        r_halted, r_rw;
    logic [2:0]  r_ridx;
    logic [1:0]  r_mw;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_wdata, mem_rdata;

    lc3b_ram #(.WIDTH(16), .DEPTH(lc3b_pkg::MEM_WORDS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    logic [15:0] ir, inc, a, b, sh, alu, ea_b, ea_w, br_tgt, j_tgt, npc;
    logic [3:0]  op;
    logic [2:0]  dr, sr1;
    logic        br_take;
    logic [7:0]  ld_byte;

    assign ir   = mem_rdata;
    assign op   = ir[15:12];
    assign dr   = ir[11:9];
    assign sr1  = ir[8:6];
    assign inc  = r_pc + 16'd2;
    assign a    = r_regs[sr1];
    assign b    = ir[5] ? {{11{ir[4]}}, ir[4:0]} : r_regs[ir[2:0]];
    assign ea_b = a + {{10{ir[5]}}, ir[5:0]};
    assign ea_w = a + {{9{ir[5]}}, ir[5:0], 1'b0};
    assign br_tgt = inc + {{6{ir[8]}}, ir[8:0], 1'b0};
    assign j_tgt  = inc + {{4{ir[10]}}, ir[10:0], 1'b0};
    assign br_take = (ir[11] & r_n) | (ir[10] & r_z) | (ir[9] & r_p);
    assign ld_byte = r_ea[0] ? mem_rdata[15:8] : mem_rdata[7:0];

    always_comb begin
        if (!ir[4]) begin
            sh = a << ir[3:0];
        end else if (!ir[5]) begin
            sh = a >> ir[3:0];
        end else begin
            sh = 16'($signed(a) >>> ir[3:0]);
        end
        unique case (op)
            lc3b_pkg::OP_ADD: alu = a + b;
            lc3b_pkg::OP_AND: alu = a & b;
            lc3b_pkg::OP_XOR: alu = a ^ b;
            default:          alu = sh;
        endcase
        unique case (op)
            lc3b_pkg::OP_BR:  npc = br_take ? br_tgt : inc;
            lc3b_pkg::OP_JSR: npc = ir[11] ? j_tgt : a;
            lc3b_pkg::OP_JMP: npc = a;
            default:          npc = inc;
        endcase
    end

    logic        accept;
    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == lc3b_pkg::ST_IDLE);
    assign o_valid = (r_state == lc3b_pkg::ST_RESULT);

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_addr  = lc3b_pkg::word_index(r_pc);
        mem_wdata = i_data;
        unique case (r_state)
            lc3b_pkg::ST_IDLE: begin
                if (accept) begin
                    if (lc3b_pkg::t_mode'(i_mode) == lc3b_pkg::MODE_STEP && r_pc != 16'd0) begin
                        n_state = lc3b_pkg::ST_FETCH;
                    end else begin
                        n_state = lc3b_pkg::ST_RESULT;
                    end
                    if (lc3b_pkg::t_mode'(i_mode) == lc3b_pkg::MODE_LOAD) begin
                        mem_we   = 1'b1;
                        mem_addr = lc3b_pkg::word_index(i_address);
                    end
                end
            end
            lc3b_pkg::ST_FETCH: begin
                n_state = lc3b_pkg::ST_DECODE;
            end
            lc3b_pkg::ST_DECODE: begin
                unique case (op)
                    lc3b_pkg::OP_LDB, lc3b_pkg::OP_STB: begin
                        n_state  = lc3b_pkg::ST_DATA;
                        mem_addr = lc3b_pkg::word_index(ea_b);
                    end
                    lc3b_pkg::OP_LDW: begin
                        n_state  = lc3b_pkg::ST_DATA;
                        mem_addr = lc3b_pkg::word_index(ea_w);
                    end
                    lc3b_pkg::OP_TRAP: begin
                        n_state  = lc3b_pkg::ST_DATA;
                        mem_addr = lc3b_pkg::word_index({7'd0, ir[7:0], 1'b0});
                    end
                    lc3b_pkg::OP_STW: begin
                        n_state   = lc3b_pkg::ST_RESULT;
                        mem_we    = 1'b1;
                        mem_addr  = lc3b_pkg::word_index(ea_w);
                        mem_wdata = r_regs[dr];
                    end
                    default: n_state = lc3b_pkg::ST_RESULT;
                endcase
            end
            lc3b_pkg::ST_DATA: begin
                n_state  = lc3b_pkg::ST_RESULT;
                mem_addr = lc3b_pkg::word_index(r_ea);
                if (lc3b_pkg::t_opcode'(r_ir[15:12]) == lc3b_pkg::OP_STB) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_ea[0] ? {r_mdata[7:0], mem_rdata[7:0]}
                                        : {mem_rdata[15:8], r_mdata[7:0]};
                end
            end
            lc3b_pkg::ST_RESULT: begin
                if (i_ready) begin
                    n_state = lc3b_pkg::ST_IDLE;
                end
            end
            default: n_state = lc3b_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lc3b_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    task automatic set_cc(input logic [15:0] v);
        r_n <= v[15];
        r_z <= (v == 16'd0);
        r_p <= !v[15] && (v != 16'd0);
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lc3b_pkg::NUM_REGS; i++) r_regs[i] <= 16'd0;
            r_pc     <= 16'd0;
            r_n      <= 1'b0;
            r_z      <= 1'b1;
            r_p      <= 1'b0;
            r_halted <= 1'b0;
            r_rw     <= 1'b0;
            r_ridx   <= 3'd0;
            r_rval   <= 16'd0;
            r_mw     <= lc3b_pkg::MW_NONE;
            r_ea     <= 16'd0;
            r_mdata  <= 16'd0;
            r_ir     <= 16'd0;
        end else begin
            unique case (r_state)
                lc3b_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_halted <= (lc3b_pkg::t_mode'(i_mode) == lc3b_pkg::MODE_STEP)
                                    && (r_pc == 16'd0);
                        r_rw    <= 1'b0;
                        r_ridx  <= 3'd0;
                        r_rval  <= 16'd0;
                        r_mw    <= lc3b_pkg::MW_NONE;
                        r_ea    <= 16'd0;
                        r_mdata <= 16'd0;
                        if (lc3b_pkg::t_mode'(i_mode) == lc3b_pkg::MODE_START) begin
                            for (int i = 0; i < lc3b_pkg::NUM_REGS; i++) r_regs[i] <= 16'd0;
                            r_pc <= i_address;
                            r_n  <= 1'b0;
                            r_z  <= 1'b1;
                            r_p  <= 1'b0;
                        end
                    end
                end
                lc3b_pkg::ST_DECODE: begin
                    r_ir <= ir;
                    r_pc <= npc;
                    unique case (op)
                        lc3b_pkg::OP_ADD, lc3b_pkg::OP_AND, lc3b_pkg::OP_XOR,
                        lc3b_pkg::OP_SHF: begin
                            r_rw <= 1'b1; r_ridx <= dr; r_rval <= alu;
                            r_regs[dr] <= alu;
                            set_cc(alu);
                        end
                        lc3b_pkg::OP_LDB: begin
                            r_rw <= 1'b1; r_ridx <= dr; r_ea <= ea_b;
                        end
                        lc3b_pkg::OP_STB: begin
                            r_mw <= lc3b_pkg::MW_BYTE; r_ea <= ea_b;
                            r_mdata <= {8'd0, r_regs[dr][7:0]};
                        end
                        lc3b_pkg::OP_LDW: begin
                            r_rw <= 1'b1; r_ridx <= dr; r_ea <= ea_w;
                        end
                        lc3b_pkg::OP_STW: begin
                            r_mw <= lc3b_pkg::MW_WORD; r_ea <= ea_w;
                            r_mdata <= r_regs[dr];
                        end
                        lc3b_pkg::OP_JSR: begin
                            r_rw <= 1'b1; r_ridx <= 3'd7; r_rval <= inc;
                            r_regs[7] <= inc;
                        end
                        lc3b_pkg::OP_LEA: begin
                            r_rw <= 1'b1; r_ridx <= dr; r_rval <= br_tgt;
                            r_regs[dr] <= br_tgt;
                        end
                        lc3b_pkg::OP_TRAP: begin
                            r_rw <= 1'b1; r_ridx <= 3'd7; r_rval <= inc;
                            r_regs[7] <= inc;
                            r_ea <= {7'd0, ir[7:0], 1'b0};
                        end
                        default: ;
                    endcase
                end
                lc3b_pkg::ST_DATA: begin
                    unique case (lc3b_pkg::t_opcode'(r_ir[15:12]))
                        lc3b_pkg::OP_LDB: begin
                            r_rval <= {{8{ld_byte[7]}}, ld_byte};
                            r_regs[r_ir[11:9]] <= {{8{ld_byte[7]}}, ld_byte};
                            set_cc({{8{ld_byte[7]}}, ld_byte});
                        end
                        lc3b_pkg::OP_LDW: begin
                            r_rval <= mem_rdata;
                            r_regs[r_ir[11:9]] <= mem_rdata;
                            set_cc(mem_rdata);
                        end
                        lc3b_pkg::OP_TRAP: begin
                            r_pc <= mem_rdata;
                            r_ea <= 16'd0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_pc          = r_pc;
    assign o_flag_n      = r_n;
    assign o_flag_z      = r_z;
    assign o_flag_p      = r_p;
    assign o_halted      = r_halted;
    assign o_reg_written = r_rw;
    assign o_reg_index   = r_ridx;
    assign o_reg_value   = r_rval;
    assign o_mem_written = r_mw;
    assign o_mem_address = (r_mw != lc3b_pkg::MW_NONE) ? r_ea : 16'd0;
    assign o_mem_data    = r_mdata;

`ifndef SYNTHESIS
    a_cc_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({r_n, r_z, r_p}))
        else $error("condition codes not one-hot");
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_halted |-> !o_reg_written && o_mem_written == lc3b_pkg::MW_NONE)
        else $error("halted step reported a write");
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready while result pending");
`endif
endmodule

// File: sim/lc3b_instruction_execute_unit_checker.sv
// Checker for lc3b_instruction_execute_unit: watches both request/result channels,
// predicts every result from its own copy of memory, registers, PC and codes.
// Depends on lc3b_pkg.
module lc3b_instruction_execute_unit_checker
    import lc3b_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_address,
    input  logic [15:0] i_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_pc,
    input  logic        i_flag_n,
    input  logic        i_flag_z,
    input  logic        i_flag_p,
    input  logic        i_halted,
    input  logic        i_reg_written,
    input  logic [2:0]  i_reg_index,
    input  logic [15:0] i_reg_value,
    input  logic [1:0]  i_mem_written,
    input  logic [15:0] i_mem_address,
    input  logic [15:0] i_mem_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] pc;
        logic        n;
        logic        z;
        logic        p;
        logic        halted;
        logic        reg_written;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic [1:0]  mem_written;
        logic [15:0] mem_address;
        logic [15:0] mem_data;
    } t_cpu_result;

    logic [15:0]  mem_model [MEM_WORDS];
    logic [15:0]  gpr [NUM_REGS];
    logic [15:0]  pc_model;
    logic         cc_n, cc_z, cc_p;
    t_cpu_result  expected_results [$];
    int           errors;

    assign o_errors  = errors;
    assign o_pending = expected_results.size();

    function automatic logic [15:0] word_at(logic [15:0] byte_addr);
        return mem_model[byte_addr[MEM_AW:1]];
    endfunction

    task automatic update_codes(input logic [15:0] v);
        cc_n = v[15];
        cc_z = (v == 16'h0000);
        cc_p = !v[15] && (v != 16'h0000);
    endtask

    task automatic execute_request(input logic [1:0] mode, input logic [15:0] addr,
                                   input logic [15:0] data, output t_cpu_result r);
        logic [15:0] ir, inc, npc, a, b, res, ea, w;
        logic [2:0]  dr, sr1;
        logic [3:0]  amt;
        logic [7:0]  bt;
        r = '0;
        if (mode == MODE_LOAD) begin
            mem_model[addr[MEM_AW:1]] = data;
        end else if (mode == MODE_START) begin
            for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
            pc_model = addr;
            cc_n = 0; cc_z = 1; cc_p = 0;
        end else if (mode == MODE_STEP) begin
            if (pc_model == 16'h0000) begin
                r.halted = 1;
            end else begin
                ir  = word_at(pc_model);
                dr  = ir[11:9];
                sr1 = ir[8:6];
                inc = pc_model + 16'd2;
                npc = inc;
                case (t_opcode'(ir[15:12]))
                    OP_BR: begin
                        if ((ir[11] && cc_n) || (ir[10] && cc_z) || (ir[9] && cc_p))
                            npc = inc + {{6{ir[8]}}, ir[8:0], 1'b0};
                    end
                    OP_ADD, OP_AND, OP_XOR: begin
                        a = gpr[sr1];
                        b = ir[5] ? {{11{ir[4]}}, ir[4:0]} : gpr[ir[2:0]];
                        if (t_opcode'(ir[15:12]) == OP_ADD) res = a + b;
                        else if (t_opcode'(ir[15:12]) == OP_AND) res = a & b;
                        else res = a ^ b;
                        r.reg_written = 1; r.reg_index = dr; r.reg_value = res;
                        update_codes(res);
                    end
                    OP_LDB: begin
                        ea = gpr[sr1] + {{10{ir[5]}}, ir[5:0]};
                        w  = word_at(ea);
                        bt = ea[0] ? w[15:8] : w[7:0];
                        res = {{8{bt[7]}}, bt};
                        r.reg_written = 1; r.reg_index = dr; r.reg_value = res;
                        update_codes(res);
                    end
                    OP_STB: begin
                        ea = gpr[sr1] + {{10{ir[5]}}, ir[5:0]};
                        bt = gpr[dr][7:0];
                        w  = word_at(ea);
                        if (ea[0]) w[15:8] = bt;
                        else w[7:0] = bt;
                        mem_model[ea[MEM_AW:1]] = w;
                        r.mem_written = MW_BYTE; r.mem_address = ea;
                        r.mem_data = {8'h00, bt};
                    end
                    OP_JSR: begin
                        if (ir[11]) npc = inc + {{4{ir[10]}}, ir[10:0], 1'b0};
                        else npc = gpr[sr1];
                        r.reg_written = 1; r.reg_index = 3'd7; r.reg_value = inc;
                    end
                    OP_LDW: begin
                        ea  = gpr[sr1] + {{9{ir[5]}}, ir[5:0], 1'b0};
                        res = word_at(ea);
                        r.reg_written = 1; r.reg_index = dr; r.reg_value = res;
                        update_codes(res);
                    end
                    OP_STW: begin
                        ea = gpr[sr1] + {{9{ir[5]}}, ir[5:0], 1'b0};
                        mem_model[ea[MEM_AW:1]] = gpr[dr];
                        r.mem_written = MW_WORD; r.mem_address = ea; r.mem_data = gpr[dr];
                    end
                    OP_JMP: npc = gpr[sr1];
                    OP_SHF: begin
                        amt = ir[3:0];
                        a = gpr[sr1];
                        if (!ir[4]) res = a << amt;
                        else if (!ir[5]) res = a >> amt;
                        else res = $signed(a) >>> amt;
                        r.reg_written = 1; r.reg_index = dr; r.reg_value = res;
                        update_codes(res);
                    end
                    OP_LEA: begin
                        r.reg_written = 1; r.reg_index = dr;
                        r.reg_value = inc + {{6{ir[8]}}, ir[8:0], 1'b0};
                    end
                    OP_TRAP: begin
                        npc = mem_model[{{(MEM_AW-8){1'b0}}, ir[7:0]}];
                        r.reg_written = 1; r.reg_index = 3'd7; r.reg_value = inc;
                    end
                    default: ;
                endcase
                if (r.reg_written) gpr[r.reg_index] = r.reg_value;
                pc_model = npc;
            end
        end
        r.pc = pc_model; r.n = cc_n; r.z = cc_z; r.p = cc_p;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            errors++;
            if (errors <= 10)
                $display("%0t mismatch on %s: expected %h, got %h", $realtime, name,
                         exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_cpu_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
            pc_model = '0;
            cc_n = 0; cc_z = 1; cc_p = 0;
            expected_results.delete();
            errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("%0t result with no request pending", $realtime);
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("pc", exp_r.pc, i_pc);
                    check_field("flag_n", exp_r.n, i_flag_n);
                    check_field("flag_z", exp_r.z, i_flag_z);
                    check_field("flag_p", exp_r.p, i_flag_p);
                    check_field("halted", exp_r.halted, i_halted);
                    check_field("reg_written", exp_r.reg_written, i_reg_written);
                    check_field("reg_index", exp_r.reg_index, i_reg_index);
                    check_field("reg_value", exp_r.reg_value, i_reg_value);
                    check_field("mem_written", exp_r.mem_written, i_mem_written);
                    check_field("mem_address", exp_r.mem_address, i_mem_address);
                    check_field("mem_data", exp_r.mem_data, i_mem_data);
                end
            end
            if (i_valid && i_ready_in) begin
                execute_request(i_mode, i_address, i_data, exp_r);
                expected_results.push_back(exp_r);
            end
        end
    end
endmodule

// File: sim/lc3b_instruction_execute_unit_tb.sv
// Testbench top for lc3b_instruction_execute_unit: loads and steps a directed program, then
// random load/start/step/none traffic, writing each unwritten word before a step reads it.
// Depends on lc3b_pkg, lc3b_instruction_execute_unit and the checker.
module lc3b_instruction_execute_unit_tb;
    import lc3b_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_mode = MODE_LOAD;
    logic [15:0] i_address = '0;
    logic [15:0] i_data = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [15:0] o_pc, o_reg_value, o_mem_address, o_mem_data;
    logic        o_flag_n, o_flag_z, o_flag_p, o_halted, o_reg_written;
    logic [2:0]  o_reg_index;
    logic [1:0]  o_mem_written;
    int          errors, pending;
    bit          no_idle = 0;
    bit          took = 0;
    int          stall_left = 0;
    int          sent = 0;

    always #6 i_clk = ~i_clk;

    lc3b_instruction_execute_unit dut (.*);

    lc3b_instruction_execute_unit_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_mode, .i_address, .i_data,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_pc(o_pc), .i_flag_n(o_flag_n),
        .i_flag_z(o_flag_z), .i_flag_p(o_flag_p), .i_halted(o_halted),
        .i_reg_written(o_reg_written), .i_reg_index(o_reg_index),
        .i_reg_value(o_reg_value), .i_mem_written(o_mem_written),
        .i_mem_address(o_mem_address), .i_mem_data(o_mem_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) took <= o_valid && i_ready;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            int left;
            left = stall_left;
            if (took) left = no_idle ? 0 : $urandom_range(0, 7);
            if (left > 0) begin
                i_ready <= 0;
                left--;
            end else begin
                i_ready <= 1;
            end
            stall_left = left;
        end
    end

    task automatic send_request(input logic [1:0] mode, input logic [15:0] addr,
                                input logic [15:0] data);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode = mode;
        i_address = addr;
        i_data = data;
        i_valid = 1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic ensure_word(input logic [15:0] byte_addr);
        if ($isunknown(checker_i.mem_model[byte_addr[MEM_AW:1]]))
            send_request(MODE_LOAD, byte_addr, 16'($urandom));
    endtask

    // write each unwritten word the next step reads, then send the step
    task automatic step_request();
        logic [15:0] pc, ir, base;
        pc = checker_i.pc_model;
        if (pc != 16'h0000) begin
            ensure_word(pc);
            ir   = checker_i.mem_model[pc[MEM_AW:1]];
            base = checker_i.gpr[ir[8:6]];
            case (t_opcode'(ir[15:12]))
                OP_LDB, OP_STB: ensure_word(base + {{10{ir[5]}}, ir[5:0]});
                OP_LDW:         ensure_word(base + {{9{ir[5]}}, ir[5:0], 1'b0});
                OP_TRAP:        ensure_word({7'd0, ir[7:0], 1'b0});
                default: ;
            endcase
        end
        send_request(MODE_STEP, 16'($urandom), 16'($urandom));
    endtask

    task automatic drain_requests();
        i_valid = 0;
        while (pending != 0) @(negedge i_clk);
    endtask

    logic [15:0] directed_prog [20] = '{
        16'h127F, 16'h546F, 16'h9642, 16'h987F, 16'hDA74, 16'hDADF, 16'hDC8F,
        16'hE028, 16'h3201, 16'h2401, 16'h7C00, 16'h6600, 16'h8000, 16'hA000,
        16'hB000, 16'h0E00, 16'h4801, 16'h0000, 16'h41C0, 16'hF005
    };

    initial begin
        int sel;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        for (int k = 0; k < 20; k++)
            send_request(MODE_LOAD, 16'h3000 + 16'(2 * k), directed_prog[k]);
        send_request(MODE_LOAD, 16'h000A, 16'h0000);
        send_request(MODE_LOAD, 16'h3060, 16'h0000);
        send_request(MODE_START, 16'h3000, 16'h0000);
        repeat (24) step_request();
        send_request(MODE_NONE, 16'h1234, 16'hABCD);
        send_request(MODE_START, 16'h0000, 16'h0000);
        step_request();

        while (sent < 1600) begin
            no_idle = ((sent / 200) % 4) == 3;
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                send_request(MODE_LOAD, 16'($urandom), 16'($urandom));
            end else if (sel < 8) begin
                if (sel == 5) drain_requests();
                send_request(MODE_START, ($urandom_range(0, 7) == 0) ? 16'h0000
                             : 16'($urandom), 16'($urandom));
            end else if (sel < 10) begin
                send_request(MODE_NONE, 16'($urandom), 16'($urandom));
            end else begin
                step_request();
            end
        end
        no_idle = 0;
        drain_requests();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("lc3b_instruction_execute_unit test passed");
        else
            $display("lc3b_instruction_execute_unit test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("lc3b_instruction_execute_unit test failed");
        $finish;
    end
endmodule
